// ----- sv/cpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants for collision position correction
// Field widths, pair kinds, register indexes, the pipeline structs and the
// signed saturating pack used by the output stage.
// ----------------------------------------------------------------------------
package cpc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W    = 32;
    localparam int TOL_W     = 16;
    localparam int SHARE_W   = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 1;
    localparam int KIND_W    = 2;
    localparam int LANES     = 3;
    localparam int SUM_W     = DATA_W + 1;
    localparam int NUM_W     = 2 * DATA_W;
    localparam int QUOT_W    = DATA_W;
    localparam int TDATA_W   = 6 * DATA_W;

    localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_TOL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CORR_SHARE = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_RIGID_RIGID  = 2'd0,
        KIND_RIGID_STATIC = 2'd1,
        KIND_STATIC_RIGID = 2'd2,
        KIND_INVALID      = 2'd3
    } pair_kind_t;

    typedef struct packed {
        logic             vld;
        pair_kind_t       kind;
        logic             sat;
        logic [LANES-1:0] cneg;
    } cpc_ctl_t;

    // correction vector as sign and magnitude, plus what the mass split needs
    typedef struct packed {
        cpc_ctl_t                     ctl;
        logic [DATA_W-1:0]            mass_b;
        logic [SUM_W-1:0]             sum;
        logic [LANES-1:0][DATA_W-1:0] cmag;
    } cpc_corr_t;

    // one step of the restoring divider, three lanes share the divisor
    typedef struct packed {
        cpc_ctl_t                     ctl;
        logic [SUM_W-1:0]             sum;
        logic [LANES-1:0][DATA_W-1:0] cmag;
        logic [LANES-1:0][SUM_W-1:0]  rem;
        logic [LANES-1:0][DATA_W-1:0] num;
        logic [LANES-1:0][QUOT_W-1:0] quot;
    } cpc_div_t;

    // sign and magnitude to two's complement, clipped; msb of result is the clip flag
    function automatic logic [DATA_W:0] pack_sat(input logic neg,
                                                 input logic [DATA_W-1:0] mag);
        logic [DATA_W-1:0] neg_mag;
        logic [DATA_W:0]   res;
        neg_mag = ~mag + 1'b1;
        if (neg) begin
            if (mag > S_MIN) begin
                res = {1'b1, S_MIN};
            end else begin
                res = {1'b0, neg_mag};
            end
        end else begin
            if (mag > S_MAX) begin
                res = {1'b1, S_MAX};
            end else begin
                res = {1'b0, mag};
            end
        end
        return res;
    endfunction

endpackage

// ----- sv/cpc_correction.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_correction: correction vector pipeline
// Four stages: excess depth, scaled magnitude with normal absolute values and
// mass sum, normal times magnitude, then shift and clip per component.
// ----------------------------------------------------------------------------
module cpc_correction #(
    parameter int FRAC_BITS = cpc_pkg::FRAC_BITS_DEF
) (
    input  logic                                             aclk,
    input  logic                                             aresetn,
    input  logic                                             en,
    input  logic                                             in_vld,
    input  logic [cpc_pkg::KIND_W-1:0]                       in_kind,
    input  logic [cpc_pkg::LANES-1:0][cpc_pkg::DATA_W-1:0]   in_normal,
    input  logic [cpc_pkg::DATA_W-1:0]                       in_depth,
    input  logic [cpc_pkg::DATA_W-1:0]                       in_mass_a,
    input  logic [cpc_pkg::DATA_W-1:0]                       in_mass_b,
    input  logic [cpc_pkg::TOL_W-1:0]                        depth_tol,
    input  logic [cpc_pkg::SHARE_W-1:0]                      corr_share,
    output cpc_pkg::cpc_corr_t                               corr_out
);
    import cpc_pkg::*;

    localparam int PRODM_W = DATA_W + SHARE_W;
    localparam int MAG_W   = PRODM_W - FRAC_BITS;
    localparam int PROD_W  = DATA_W + MAG_W;
    localparam int M_W     = PROD_W - FRAC_BITS;
    localparam logic [M_W-1:0] HALF_M = M_W'({1'b0, S_MIN});
    localparam logic [M_W-1:0] MAXP_M = M_W'({1'b0, S_MAX});

    // stage 1
    logic                         s1_vld_reg;
    pair_kind_t                   s1_kind_reg;
    logic [LANES-1:0][DATA_W-1:0] s1_normal_reg;
    logic [DATA_W-1:0]            s1_excess_reg, s1_excess_next;
    logic [DATA_W-1:0]            s1_ma_reg, s1_mb_reg;
    // stage 2
    logic                         s2_vld_reg;
    pair_kind_t                   s2_kind_reg;
    logic [LANES-1:0]             s2_nneg_reg, s2_nneg_next;
    logic [LANES-1:0][DATA_W-1:0] s2_nmag_reg, s2_nmag_next;
    logic [MAG_W-1:0]             s2_mag_reg, s2_mag_next;
    logic [SUM_W-1:0]             s2_sum_reg, s2_sum_next;
    logic [DATA_W-1:0]            s2_mb_reg, s2_mb_next;
    // stage 3
    logic                         s3_vld_reg;
    pair_kind_t                   s3_kind_reg;
    logic [LANES-1:0]             s3_nneg_reg;
    logic [LANES-1:0][PROD_W-1:0] s3_prod_reg, s3_prod_next;
    logic [SUM_W-1:0]             s3_sum_reg;
    logic [DATA_W-1:0]            s3_mb_reg;
    // stage 4
    cpc_corr_t                    s4_reg, s4_next;

    logic [DATA_W-1:0]  tol_ext;
    logic [PRODM_W-1:0] mag_full;
    logic [SUM_W-1:0]   sum_raw;

    always_comb begin
        tol_ext        = DATA_W'(depth_tol);
        s1_excess_next = (in_depth > tol_ext) ? (in_depth - tol_ext) : '0;
    end

    always_comb begin
        mag_full    = PRODM_W'(s1_excess_reg) * PRODM_W'(corr_share);
        s2_mag_next = mag_full[PRODM_W-1:FRAC_BITS];
        sum_raw     = {1'b0, s1_ma_reg} + {1'b0, s1_mb_reg};
        // both masses zero splits evenly
        if (sum_raw == '0) begin
            s2_sum_next = SUM_W'(2);
            s2_mb_next  = DATA_W'(1);
        end else begin
            s2_sum_next = sum_raw;
            s2_mb_next  = s1_mb_reg;
        end
        for (int k = 0; k < LANES; k++) begin
            s2_nneg_next[k] = s1_normal_reg[k][DATA_W-1];
            s2_nmag_next[k] = s2_nneg_next[k] ? (~s1_normal_reg[k] + 1'b1)
                                              : s1_normal_reg[k];
        end
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            s3_prod_next[k] = PROD_W'(s2_nmag_reg[k]) * PROD_W'(s2_mag_reg);
        end
    end

    always_comb begin
        logic [M_W-1:0] m;
        logic           over;
        s4_next          = '0;
        s4_next.ctl.vld  = s3_vld_reg;
        s4_next.ctl.kind = s3_kind_reg;
        s4_next.sum      = s3_sum_reg;
        s4_next.mass_b   = s3_mb_reg;
        for (int k = 0; k < LANES; k++) begin
            m    = s3_prod_reg[k][PROD_W-1:FRAC_BITS];
            over = s3_nneg_reg[k] ? (m > HALF_M) : (m > MAXP_M);
            if (over) begin
                s4_next.cmag[k] = s3_nneg_reg[k] ? S_MIN : S_MAX;
            end else begin
                s4_next.cmag[k] = m[DATA_W-1:0];
            end
            s4_next.ctl.cneg[k] = s3_nneg_reg[k] && (s4_next.cmag[k] != '0);
            s4_next.ctl.sat     = s4_next.ctl.sat | over;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            s3_vld_reg     <= 1'b0;
            s4_reg.ctl.vld <= 1'b0;
        end else if (en) begin
            s1_vld_reg    <= in_vld && (in_kind != KIND_INVALID);
            s1_kind_reg   <= pair_kind_t'(in_kind);
            s1_normal_reg <= in_normal;
            s1_excess_reg <= s1_excess_next;
            s1_ma_reg     <= in_mass_a;
            s1_mb_reg     <= in_mass_b;

            s2_vld_reg    <= s1_vld_reg;
            s2_kind_reg   <= s1_kind_reg;
            s2_nneg_reg   <= s2_nneg_next;
            s2_nmag_reg   <= s2_nmag_next;
            s2_mag_reg    <= s2_mag_next;
            s2_sum_reg    <= s2_sum_next;
            s2_mb_reg     <= s2_mb_next;

            s3_vld_reg    <= s2_vld_reg;
            s3_kind_reg   <= s2_kind_reg;
            s3_nneg_reg   <= s2_nneg_reg;
            s3_prod_reg   <= s3_prod_next;
            s3_sum_reg    <= s2_sum_reg;
            s3_mb_reg     <= s2_mb_reg;

            s4_reg        <= s4_next;
        end
    end

    assign corr_out = s4_reg;

endmodule

// ----- sv/cpc_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_div_stage: one quotient bit of the mass split divider
// Shifts in one numerator bit per lane, trial subtracts the mass sum and
// registers the new remainder and quotient bit.
// ----------------------------------------------------------------------------
module cpc_div_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  cpc_pkg::cpc_div_t d_in,
    output cpc_pkg::cpc_div_t d_out
);
    import cpc_pkg::*;

    cpc_div_t stage_reg, stage_next;

    always_comb begin
        logic [SUM_W:0] trial;
        logic [SUM_W:0] divisor;
        logic [SUM_W:0] diff;
        logic           ge;
        stage_next = d_in;
        divisor    = {1'b0, d_in.sum};
        for (int k = 0; k < LANES; k++) begin
            trial = {d_in.rem[k], d_in.num[k][DATA_W-1]};
            diff  = trial - divisor;
            ge    = trial >= divisor;
            stage_next.rem[k]  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            stage_next.num[k]  = {d_in.num[k][DATA_W-2:0], 1'b0};
            stage_next.quot[k] = {d_in.quot[k][QUOT_W-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.ctl.vld <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign d_out = stage_reg;

endmodule

// ----- sv/cpc_mass_split.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_mass_split: mass share split and output register
// Forms c*mass_b per lane, runs it through a bit-per-stage divider by the
// mass sum, derives the other body's share from quotient and remainder and
// packs both moves with saturation into the output register.
// ----------------------------------------------------------------------------
module cpc_mass_split (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           en,
    input  cpc_pkg::cpc_corr_t                             corr_in,
    output logic                                           out_vld,
    output logic [cpc_pkg::LANES-1:0][cpc_pkg::DATA_W-1:0] move_a,
    output logic [cpc_pkg::LANES-1:0][cpc_pkg::DATA_W-1:0] move_b,
    output logic                                           out_sat
);
    import cpc_pkg::*;

    cpc_div_t div_init_reg, div_init_next;
    cpc_div_t div_pipe [0:QUOT_W];

    logic                         out_vld_reg;
    logic [LANES-1:0][DATA_W-1:0] move_a_reg, move_a_next;
    logic [LANES-1:0][DATA_W-1:0] move_b_reg, move_b_next;
    logic                         sat_reg, sat_next;

    always_comb begin
        logic [NUM_W-1:0] prod;
        div_init_next      = '0;
        div_init_next.ctl  = corr_in.ctl;
        div_init_next.sum  = corr_in.sum;
        div_init_next.cmag = corr_in.cmag;
        for (int k = 0; k < LANES; k++) begin
            prod = NUM_W'(corr_in.cmag[k]) * NUM_W'(corr_in.mass_b);
            // upper half is below the sum since mass_b never exceeds it
            div_init_next.rem[k] = {1'b0, prod[NUM_W-1:DATA_W]};
            div_init_next.num[k] = prod[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_init_reg.ctl.vld <= 1'b0;
        end else if (en) begin
            div_init_reg <= div_init_next;
        end
    end

    assign div_pipe[0] = div_init_reg;

    for (genvar gi = 0; gi < QUOT_W; gi++) begin : g_div
        cpc_div_stage u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .d_in    (div_pipe[gi]),
            .d_out   (div_pipe[gi+1])
        );
    end

    always_comb begin
        cpc_div_t          d;
        logic [DATA_W-1:0] qa;
        logic [DATA_W-1:0] qb;
        logic              b_neg;
        logic [DATA_W:0]   pa;
        logic [DATA_W:0]   pb;
        d        = div_pipe[QUOT_W];
        sat_next = d.ctl.sat;
        for (int k = 0; k < LANES; k++) begin
            qa    = d.quot[k];
            // c*ma/sum = c - qa, less one when c*mb/sum left a remainder
            qb    = d.cmag[k] - qa - DATA_W'(d.rem[k] != '0);
            b_neg = !d.ctl.cneg[k] && (d.cmag[k] != '0);
            pa    = '0;
            pb    = '0;
            case (d.ctl.kind)
                KIND_RIGID_RIGID: begin
                    pa = pack_sat(d.ctl.cneg[k], qa);
                    pb = pack_sat(b_neg, qb);
                end
                KIND_RIGID_STATIC: begin
                    pa = pack_sat(d.ctl.cneg[k], d.cmag[k]);
                end
                KIND_STATIC_RIGID: begin
                    pb = pack_sat(b_neg, d.cmag[k]);
                end
                default: begin
                    pa = '0;
                    pb = '0;
                end
            endcase
            move_a_next[k] = pa[DATA_W-1:0];
            move_b_next[k] = pb[DATA_W-1:0];
            sat_next       = sat_next | pa[DATA_W] | pb[DATA_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= div_pipe[QUOT_W].ctl.vld;
            move_a_reg  <= move_a_next;
            move_b_reg  <= move_b_next;
            sat_reg     <= sat_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign move_a  = move_a_reg;
    assign move_b  = move_b_reg;
    assign out_sat = sat_reg;

endmodule

// ----- sv/collision_position_correction_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// collision_position_correction_top: contact position correction
// Per contact: excess depth times share along the normal, split by mass
// share between the two bodies, saturated Q16.16 moves.
//
//   channel | dir | tdata                            | tuser
//   s_      | in  | normals x,y,z, depth, mass a, b  | pair kind
//   m_      | out | moves a x,y,z, moves b x,y,z     | saturated
//   cfg_    | in  | write enable, index, data        | -
//
// One word per cycle in and out unless the output stalls; it passes four
// correction stages, one multiply stage, 32 divider stages (one quotient
// bit each) and the output register; invalid pairs drop at the first stage.
// Synchronous active-low reset clears all valid bits and loads the register
// defaults. A stall at the output freezes the whole pipeline.
// ----------------------------------------------------------------------------
module collision_position_correction_top #(
    parameter int FRAC_BITS = cpc_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // normal_x, normal_y, normal_z, pen_depth, mass_a, mass_b
    input  logic [cpc_pkg::TDATA_W-1:0]      s_tdata,
    // pair_kind
    input  logic [cpc_pkg::KIND_W-1:0]       s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // move_a_x, move_a_y, move_a_z, move_b_x, move_b_y, move_b_z
    output logic [cpc_pkg::TDATA_W-1:0]      m_tdata,
    // saturated
    output logic [0:0]                       m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_wr_en,
    input  logic [cpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpc_pkg::CFG_W-1:0]        cfg_data
);
    import cpc_pkg::*;

    logic [TOL_W-1:0]   depth_tol_reg;
    logic [SHARE_W-1:0] corr_share_reg;

    logic                         adv;
    logic [LANES-1:0][DATA_W-1:0] normal;
    cpc_corr_t                    corr;
    logic [LANES-1:0][DATA_W-1:0] move_a;
    logic [LANES-1:0][DATA_W-1:0] move_b;
    logic                         out_vld;
    logic                         out_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_tol_reg  <= TOL_W'(7);
            corr_share_reg <= SHARE_W'(65536);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEPTH_TOL:  depth_tol_reg  <= cfg_data[TOL_W-1:0];
                REG_CORR_SHARE: corr_share_reg <= cfg_data[SHARE_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline moves whenever the output word is gone or being taken
    assign adv      = !out_vld || m_tready;
    assign s_tready = adv;

    for (genvar gk = 0; gk < LANES; gk++) begin : g_norm
        assign normal[gk] = s_tdata[gk*DATA_W +: DATA_W];
    end

    cpc_correction #(
        .FRAC_BITS (FRAC_BITS)
    ) u_correction (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_vld     (s_tvalid),
        .in_kind    (s_tuser),
        .in_normal  (normal),
        .in_depth   (s_tdata[3*DATA_W +: DATA_W]),
        .in_mass_a  (s_tdata[4*DATA_W +: DATA_W]),
        .in_mass_b  (s_tdata[5*DATA_W +: DATA_W]),
        .depth_tol  (depth_tol_reg),
        .corr_share (corr_share_reg),
        .corr_out   (corr)
    );

    cpc_mass_split u_mass_split (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (adv),
        .corr_in (corr),
        .out_vld (out_vld),
        .move_a  (move_a),
        .move_b  (move_b),
        .out_sat (out_sat)
    );

    assign m_tvalid   = out_vld;
    assign m_tdata    = {move_b, move_a};
    assign m_tuser[0] = out_sat;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // the two bodies never both move in the negative direction along an axis
    a_opposite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(move_a[0][DATA_W-1] && move_b[0][DATA_W-1])
                  && !(move_a[1][DATA_W-1] && move_b[1][DATA_W-1])
                  && !(move_a[2][DATA_W-1] && move_b[2][DATA_W-1]))
        else $error("both bodies moved in the negative direction");

    // input only back-pressured by a held output word
    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output stall");

endmodule
